FILE: rtl/ulsp_pkg.sv
// ----------------------------------------------------------------------------
// ulsp_pkg
// Shared constants and types for the Ulam spiral index-to-coordinate unit.
// ----------------------------------------------------------------------------
`default_nettype none

package ulsp_pkg;

    // width of each output coordinate, two's complement
    localparam int COORD_BITS = 16;

    // sideband carried next to the square-root state: index is in range
    // (n >= 2) and the magnitude of n itself
    typedef struct packed {
        logic        live;
        logic [30:0] n;
    } ulsp_side_t;

    // which of the four ring sides the distance from the corner lands on
    typedef enum logic [1:0] {
        SIDE_EAST,
        SIDE_SOUTH,
        SIDE_WEST,
        SIDE_NORTH
    } side_t;

endpackage

`default_nettype wire

FILE: rtl/ulsp_sqrt_step.sv
// ----------------------------------------------------------------------------
// ulsp_sqrt_step
// One registered digit step of a restoring integer square root. Takes the
// next two radicand bits, tries to extend the partial root by a one bit,
// and keeps the remainder. Carries a sideband word alongside.
// ----------------------------------------------------------------------------
`default_nettype none

module ulsp_sqrt_step #(
    parameter int R = 16
) (
    input  wire logic                aclk,
    input  wire logic                aresetn,
    // upstream
    input  wire logic                in_valid,
    output logic                     in_ready,
    input  wire logic [R:0]          in_rem,
    input  wire logic [R-1:0]        in_root,
    input  wire logic [2*R-1:0]      in_rad,
    input  wire ulsp_pkg::ulsp_side_t in_side,
    // downstream
    output logic                     out_valid,
    input  wire logic                out_ready,
    output logic [R:0]               out_rem,
    output logic [R-1:0]             out_root,
    output logic [2*R-1:0]           out_rad,
    output ulsp_pkg::ulsp_side_t     out_side
);

    logic                 valid_reg;
    logic [R:0]           rem_reg;
    logic [R-1:0]         root_reg;
    logic [2*R-1:0]       rad_reg;
    ulsp_pkg::ulsp_side_t side_reg;

    logic [R+2:0]   work;
    logic [R+2:0]   trial;
    logic [R+2:0]   diff;
    logic           fits;
    logic [R:0]     rem_next;
    logic [R-1:0]   root_next;
    logic [2*R-1:0] rad_next;

    // trial subtract of (4*root + 1) from the shifted-in remainder
    always_comb begin
        work      = {in_rem, in_rad[2*R-1:2*R-2]};
        trial     = (R+3)'({in_root, 2'b01});
        diff      = work - trial;
        fits      = (work >= trial);
        rem_next  = fits ? diff[R:0] : work[R:0];
        root_next = {in_root[R-2:0], fits};
        rad_next  = {in_rad[2*R-3:0], 2'b00};
    end

    assign in_ready = !valid_reg || out_ready;

    // stage register
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            valid_reg <= 1'b0;
        end else if (in_ready) begin
            valid_reg <= in_valid;
        end
    end

    always_ff @(posedge aclk) begin
        if (in_ready && in_valid) begin
            rem_reg  <= rem_next;
            root_reg <= root_next;
            rad_reg  <= rad_next;
            side_reg <= in_side;
        end
    end

    assign out_valid = valid_reg;
    assign out_rem   = rem_reg;
    assign out_root  = root_reg;
    assign out_rad   = rad_reg;
    assign out_side  = side_reg;

endmodule

`default_nettype wire

FILE: rtl/ulsp_ring.sv
// ----------------------------------------------------------------------------
// ulsp_ring
// Ring and corner stages: k = ceil(sqrt(n)) / 2 from the root of n - 1, the
// corner square (2k+1)^2, then the distance back from the corner to n.
// ----------------------------------------------------------------------------
`default_nettype none

module ulsp_ring #(
    parameter int R = 16,
    parameter int W = 31
) (
    input  wire logic                aclk,
    input  wire logic                aresetn,
    // upstream
    input  wire logic                in_valid,
    output logic                     in_ready,
    input  wire logic [R-1:0]        in_root,
    input  wire ulsp_pkg::ulsp_side_t in_side,
    // downstream
    output logic                     out_valid,
    input  wire logic                out_ready,
    output logic                     out_live,
    output logic [R-1:0]             out_k,
    output logic [R+2:0]             out_dist
);

    localparam int CB = 2 * R + 2;

    // stage A: ring and corner square
    logic           a_valid_reg;
    logic           a_live_reg;
    logic [W-1:0]   a_n_reg;
    logic [R-1:0]   a_k_reg;
    logic [CB-1:0]  a_corner_reg;
    logic           a_ready;

    logic [R:0]     ceil_root;
    logic [R-1:0]   k_next;
    logic [R:0]     edge_len;
    logic [CB-1:0]  corner_next;

    always_comb begin
        ceil_root   = {1'b0, in_root} + (R+1)'(1);
        k_next      = ceil_root[R:1];
        edge_len    = {k_next, 1'b1};
        corner_next = CB'(edge_len) * CB'(edge_len);
    end

    assign in_ready = !a_valid_reg || a_ready;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            a_valid_reg <= 1'b0;
        end else if (in_ready) begin
            a_valid_reg <= in_valid;
        end
    end

    always_ff @(posedge aclk) begin
        if (in_ready && in_valid) begin
            a_live_reg   <= in_side.live;
            a_n_reg      <= W'(in_side.n);
            a_k_reg      <= k_next;
            a_corner_reg <= corner_next;
        end
    end

    // stage B: distance from the corner square
    logic           b_valid_reg;
    logic           b_live_reg;
    logic [R-1:0]   b_k_reg;
    logic [R+2:0]   b_dist_reg;
    logic [CB-1:0]  dist_full;

    assign dist_full = a_corner_reg - CB'(a_n_reg);
    assign a_ready   = !b_valid_reg || out_ready;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            b_valid_reg <= 1'b0;
        end else if (a_ready) begin
            b_valid_reg <= a_valid_reg;
        end
    end

    always_ff @(posedge aclk) begin
        if (a_ready && a_valid_reg) begin
            b_live_reg <= a_live_reg;
            b_k_reg    <= a_k_reg;
            b_dist_reg <= dist_full[R+2:0];
        end
    end

    assign out_valid = b_valid_reg;
    assign out_live  = b_live_reg;
    assign out_k     = b_k_reg;
    assign out_dist  = b_dist_reg;

endmodule

`default_nettype wire

FILE: rtl/ulsp_fold.sv
// ----------------------------------------------------------------------------
// ulsp_fold
// Side and offset stages: splits the corner distance by 2k into a side
// (two compare-subtract steps) and an offset, then places the point on the
// ring and holds it in the output register.
// ----------------------------------------------------------------------------
`default_nettype none

module ulsp_fold #(
    parameter int R = 16
) (
    input  wire logic                              aclk,
    input  wire logic                              aresetn,
    // upstream
    input  wire logic                              in_valid,
    output logic                                   in_ready,
    input  wire logic                              in_live,
    input  wire logic [R-1:0]                      in_k,
    input  wire logic [R+2:0]                      in_dist,
    // downstream
    output logic                                   out_valid,
    input  wire logic                              out_ready,
    output logic signed [ulsp_pkg::COORD_BITS-1:0] out_x,
    output logic signed [ulsp_pkg::COORD_BITS-1:0] out_y
);

    localparam int CW = ulsp_pkg::COORD_BITS;

    // stage C: side = dist / 2k, offset = dist % 2k (dist < 8k)
    logic                c_valid_reg;
    logic                c_live_reg;
    logic [R-1:0]        c_k_reg;
    logic [R:0]          c_off_reg;
    ulsp_pkg::side_t     c_side_reg;
    logic                c_ready;

    logic [R+2:0] four_k;
    logic         hi;
    logic [R+2:0] d1;
    logic [R+1:0] span;
    logic         lo;
    logic [R+1:0] d2;

    always_comb begin
        four_k = (R+3)'({in_k, 2'b00});
        hi     = (in_dist >= four_k);
        d1     = hi ? (in_dist - four_k) : in_dist;
        span   = (R+2)'({in_k, 1'b0});
        lo     = (d1[R+1:0] >= span);
        d2     = lo ? (d1[R+1:0] - span) : d1[R+1:0];
    end

    assign in_ready = !c_valid_reg || c_ready;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            c_valid_reg <= 1'b0;
        end else if (in_ready) begin
            c_valid_reg <= in_valid;
        end
    end

    always_ff @(posedge aclk) begin
        if (in_ready && in_valid) begin
            c_live_reg <= in_live;
            c_k_reg    <= in_k;
            c_off_reg  <= d2[R:0];
            c_side_reg <= ulsp_pkg::side_t'({hi, lo});
        end
    end

    // stage D: place the point on its side
    logic                  d_valid_reg;
    logic signed [CW-1:0]  d_x_reg;
    logic signed [CW-1:0]  d_y_reg;

    logic signed [R+1:0]   rk;
    logic signed [R+1:0]   ro;
    logic signed [R+1:0]   x_ring;
    logic signed [R+1:0]   y_ring;
    logic [CW+R+1:0]       x_wide;
    logic [CW+R+1:0]       y_wide;
    logic signed [CW-1:0]  x_next;
    logic signed [CW-1:0]  y_next;

    always_comb begin
        rk = $signed({2'b00, c_k_reg});
        ro = $signed({1'b0, c_off_reg});
        case (c_side_reg)
            ulsp_pkg::SIDE_EAST: begin
                x_ring = rk;
                y_ring = rk - ro;
            end
            ulsp_pkg::SIDE_SOUTH: begin
                x_ring = rk - ro;
                y_ring = -rk;
            end
            ulsp_pkg::SIDE_WEST: begin
                x_ring = -rk;
                y_ring = ro - rk;
            end
            ulsp_pkg::SIDE_NORTH: begin
                x_ring = ro - rk;
                y_ring = rk;
            end
            default: begin
                x_ring = '0;
                y_ring = '0;
            end
        endcase
        // sign-extend to a wide word, then keep the coordinate width
        x_wide = {{CW{x_ring[R+1]}}, x_ring};
        y_wide = {{CW{y_ring[R+1]}}, y_ring};
        x_next = c_live_reg ? $signed(x_wide[CW-1:0]) : '0;
        y_next = c_live_reg ? $signed(y_wide[CW-1:0]) : '0;
    end

    assign c_ready = !d_valid_reg || out_ready;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            d_valid_reg <= 1'b0;
        end else if (c_ready) begin
            d_valid_reg <= c_valid_reg;
        end
    end

    always_ff @(posedge aclk) begin
        if (c_ready && c_valid_reg) begin
            d_x_reg <= x_next;
            d_y_reg <= y_next;
        end
    end

    assign out_valid = d_valid_reg;
    assign out_x     = d_x_reg;
    assign out_y     = d_y_reg;

endmodule

`default_nettype wire

FILE: rtl/ulam_spiral_index_to_xy_unit.sv
// ----------------------------------------------------------------------------
// ulam_spiral_index_to_xy_unit
// Maps a signed Ulam spiral index to its lattice point (x, y). Indices of
// one or less give the origin.
// ----------------------------------------------------------------------------
//  channel   direction  ports                          word
//  s_        in         s_valid s_ready s_index        32-bit signed index
//  m_        out        m_valid m_ready m_x_coord      16-bit signed x, y
//                               m_y_coord
//
//  One word per cycle in and out while neither channel applies back-pressure.
//  Stages: input register, R = INDEX_BITS/2 (rounded down) square-root stages
//  of one digit each, corner multiply, corner distance, side split, output register.
//  Each stage has its own valid bit and holds under back-pressure, so
//  bubbles close up and a stall loses nothing. Reset clears the valid bits.
// ----------------------------------------------------------------------------
`default_nettype none

module ulam_spiral_index_to_xy_unit #(
    parameter int INDEX_BITS = 32
) (
    input  wire logic                                   aclk,
    input  wire logic                                   aresetn,
    // input words
    input  wire logic                                   s_valid,
    output logic                                        s_ready,
    input  wire logic signed [31:0]                     s_index,
    // result words
    output logic                                        m_valid,
    input  wire logic                                   m_ready,
    output logic signed [ulsp_pkg::COORD_BITS-1:0]      m_x_coord,
    output logic signed [ulsp_pkg::COORD_BITS-1:0]      m_y_coord
);

    localparam int W  = INDEX_BITS - 1;   // magnitude bits of a positive index
    localparam int R  = (W + 1) / 2;      // root digits
    localparam int VB = 2 * R;            // radicand bits

    // input stage: sign check, n >= 2, radicand n - 1
    logic [INDEX_BITS-1:0] raw;
    logic [W-1:0]          mag;
    logic                  live;
    logic [W-1:0]          mag_m1;

    logic                  in_valid_reg;
    logic [VB-1:0]         in_rad_reg;
    ulsp_pkg::ulsp_side_t  in_side_reg;
    ulsp_pkg::ulsp_side_t  side_next;

    always_comb begin
        raw            = s_index[INDEX_BITS-1:0];
        mag            = raw[W-1:0];
        live           = !raw[INDEX_BITS-1] && (mag > W'(1));
        mag_m1         = live ? (mag - W'(1)) : '0;
        side_next.live = live;
        side_next.n    = 31'(mag);
    end

    // square-root chain, stage 0 is the input register
    logic           st_valid [0:R];
    logic           st_ready [0:R];
    logic [R:0]     st_rem   [0:R];
    logic [R-1:0]   st_root  [0:R];
    logic [VB-1:0]  st_rad   [0:R];
    ulsp_pkg::ulsp_side_t st_side [0:R];

    assign s_ready = !in_valid_reg || st_ready[0];

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            in_valid_reg <= 1'b0;
        end else if (s_ready) begin
            in_valid_reg <= s_valid;
        end
    end

    always_ff @(posedge aclk) begin
        if (s_ready && s_valid) begin
            in_rad_reg  <= VB'(mag_m1);
            in_side_reg <= side_next;
        end
    end

    assign st_valid[0] = in_valid_reg;
    assign st_rem[0]   = '0;
    assign st_root[0]  = '0;
    assign st_rad[0]   = in_rad_reg;
    assign st_side[0]  = in_side_reg;

    for (genvar j = 0; j < R; j++) begin : g_sqrt
        ulsp_sqrt_step #(
            .R(R)
        ) u_step (
            .aclk      (aclk),
            .aresetn   (aresetn),
            .in_valid  (st_valid[j]),
            .in_ready  (st_ready[j]),
            .in_rem    (st_rem[j]),
            .in_root   (st_root[j]),
            .in_rad    (st_rad[j]),
            .in_side   (st_side[j]),
            .out_valid (st_valid[j+1]),
            .out_ready (st_ready[j+1]),
            .out_rem   (st_rem[j+1]),
            .out_root  (st_root[j+1]),
            .out_rad   (st_rad[j+1]),
            .out_side  (st_side[j+1])
        );
    end

    // ring and corner distance
    logic           rg_valid;
    logic           rg_ready;
    logic           rg_live;
    logic [R-1:0]   rg_k;
    logic [R+2:0]   rg_dist;

    ulsp_ring #(
        .R(R),
        .W(W)
    ) u_ring (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .in_valid  (st_valid[R]),
        .in_ready  (st_ready[R]),
        .in_root   (st_root[R]),
        .in_side   (st_side[R]),
        .out_valid (rg_valid),
        .out_ready (rg_ready),
        .out_live  (rg_live),
        .out_k     (rg_k),
        .out_dist  (rg_dist)
    );

    // side split and output register
    ulsp_fold #(
        .R(R)
    ) u_fold (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .in_valid  (rg_valid),
        .in_ready  (rg_ready),
        .in_live   (rg_live),
        .in_k      (rg_k),
        .in_dist   (rg_dist),
        .out_valid (m_valid),
        .out_ready (m_ready),
        .out_x     (m_x_coord),
        .out_y     (m_y_coord)
    );

endmodule

`default_nettype wire

FILE: sim/tb_ulam_spiral_index_to_xy_unit.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb_ulam_spiral_index_to_xy_unit
// Streams signed spiral indices through the unit and checks each (x, y)
// word against a lattice-point predictor built from an integer ceil-sqrt.
// Both channels stall at random, with one long stretch at full rate.
// ----------------------------------------------------------------------------

module tb_ulam_spiral_index_to_xy_unit;

    localparam int INDEX_BITS = 32;
    // input reg, one stage per root digit, four more stages
    localparam int LATENCY    = INDEX_BITS / 2 + 5;
    localparam int STALL_PCT  = 24;
    localparam int WDOG_LIMIT = 2000;
    localparam longint IDX_MAX = 64'd2147483647;
    localparam int TOP_RING   = 23170;

    typedef struct {
        logic [31:0]                             index;
        logic signed [ulsp_pkg::COORD_BITS-1:0]  x;
        logic signed [ulsp_pkg::COORD_BITS-1:0]  y;
    } lattice_point_t;

    logic                                    aclk      = 1'b0;
    logic                                    aresetn   = 1'b0;
    logic                                    s_valid   = 1'b0;
    logic                                    s_ready;
    logic signed [31:0]                      s_index   = '0;
    logic                                    m_valid;
    logic                                    m_ready   = 1'b0;
    logic signed [ulsp_pkg::COORD_BITS-1:0]  m_x_coord;
    logic signed [ulsp_pkg::COORD_BITS-1:0]  m_y_coord;

    logic           stall_en = 1'b1;
    int             err_count = 0;
    int             idle_cycles = 0;
    lattice_point_t pending_points[$];

    ulam_spiral_index_to_xy_unit #(
        .INDEX_BITS(INDEX_BITS)
    ) dut (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .s_valid  (s_valid),
        .s_ready  (s_ready),
        .s_index  (s_index),
        .m_valid  (m_valid),
        .m_ready  (m_ready),
        .m_x_coord(m_x_coord),
        .m_y_coord(m_y_coord)
    );

    // 2 ns clock
    always begin
        #1 aclk = 1'b1;
        #1 aclk = 1'b0;
    end

    // point on the square spiral for one input word
    function automatic lattice_point_t spiral_point(input logic [31:0] raw);
        lattice_point_t     pt;
        logic signed [31:0] ext;
        longint             n;
        longint             lo;
        longint             hi;
        longint             mid;
        longint             ring;
        longint             corner_gap;
        longint             span;
        longint             off;
        longint             px;
        longint             py;
        ulsp_pkg::side_t    side;
        pt.index = raw;
        // only the low INDEX_BITS bits count, sign-extended
        ext = $signed(raw << (32 - INDEX_BITS)) >>> (32 - INDEX_BITS);
        n   = ext;
        px  = 0;
        py  = 0;
        if (n > 1) begin
            // smallest m with m*m >= n
            lo = 0;
            hi = 65536;
            while (lo < hi) begin
                mid = (lo + hi) / 2;
                if (mid * mid >= n) hi = mid;
                else lo = mid + 1;
            end
            ring       = lo / 2;
            span       = 2 * ring;
            corner_gap = (span + 1) * (span + 1) - n;
            side       = ulsp_pkg::side_t'(corner_gap / span);
            off        = corner_gap % span;
            case (side)
                ulsp_pkg::SIDE_EAST: begin
                    px = ring;        py = ring - off;
                end
                ulsp_pkg::SIDE_SOUTH: begin
                    px = ring - off;  py = -ring;
                end
                ulsp_pkg::SIDE_WEST: begin
                    px = -ring;       py = -ring + off;
                end
                ulsp_pkg::SIDE_NORTH: begin
                    px = -ring + off; py = ring;
                end
                default: begin
                    px = 0;           py = 0;
                end
            endcase
        end
        pt.x = px[ulsp_pkg::COORD_BITS-1:0];
        pt.y = py[ulsp_pkg::COORD_BITS-1:0];
        return pt;
    endfunction

    task automatic report_mismatch(input string msg);
        err_count++;
        $display("ERROR @%0t: %s", $realtime, msg);
    endtask

    // one word into the unit, with random idle ahead of it
    task automatic send_index(input longint value);
        while (stall_en && $urandom_range(99) < STALL_PCT) begin
            s_valid <= 1'b0;
            s_index <= $urandom;
            @(posedge aclk);
        end
        s_valid <= 1'b1;
        s_index <= value[31:0];
        do @(posedge aclk); while (!s_ready);
        pending_points.push_back(spiral_point(value[31:0]));
    endtask

    // random index, biased toward ring corners and side boundaries
    function automatic longint pick_index();
        int     kind;
        longint k;
        longint corner;
        longint v;
        kind = $urandom_range(99);
        if (kind < 20) begin
            v = longint'($signed($urandom));
        end else if (kind < 30) begin
            v = 1 - longint'($urandom_range(0, 40));
        end else if (kind < 55) begin
            v = $urandom_range(2, 2000);
        end else if (kind < 75) begin
            k      = $urandom_range(1, TOP_RING - 1);
            corner = (2 * k + 1) * (2 * k + 1);
            v      = corner + longint'($urandom_range(0, 4)) - 2;
        end else if (kind < 90) begin
            k      = $urandom_range(1, TOP_RING - 1);
            corner = (2 * k + 1) * (2 * k + 1);
            v      = corner - longint'($urandom_range(0, 3)) * 2 * k
                   + longint'($urandom_range(0, 2)) - 1;
        end else begin
            v = IDX_MAX - longint'($urandom_range(0, 200000));
        end
        if (v > IDX_MAX) v = IDX_MAX;
        return v;
    endfunction

    // field extremes and the top ring
    task automatic test_extremes();
        send_index(-64'sd2147483648);
        send_index(-1);
        send_index(0);
        send_index(1);
        send_index(IDX_MAX);
        send_index(64'd2147302921);     // corner of ring 23169
        send_index(64'd2147302922);     // first index of the top ring
        send_index(64'h5555_5555);
        send_index(64'h2AAA_AAAA);
        send_index(64'h4000_0000);
        send_index(-64'sd2);
    endtask

    // every side of the first ring, the step into the second, and the ring 2 and 3 corners with the step between them
    task automatic test_first_rings();
        for (int n = 2; n <= 10; n++) send_index(n);
        send_index(25);
        send_index(26);
        send_index(49);
    endtask

    task automatic test_random_mix(input int count);
        for (int i = 0; i < count; i++) send_index(pick_index());
    endtask

    // no idling on either side
    task automatic test_full_rate(input int count);
        stall_en <= 1'b0;
        for (int i = 0; i < count; i++) send_index(pick_index());
        stall_en <= 1'b1;
    endtask

    // result side back-pressure
    always @(posedge aclk) begin
        if (stall_en)
            m_ready <= ($urandom_range(99) >= STALL_PCT);
        else
            m_ready <= 1'b1;
    end

    // check each result word against the oldest expectation
    always @(posedge aclk) begin
        lattice_point_t exp_pt;
        if (aresetn && m_valid && m_ready) begin
            if (pending_points.size() == 0) begin
                report_mismatch($sformatf("unexpected word x=%0d y=%0d",
                                          m_x_coord, m_y_coord));
            end else begin
                exp_pt = pending_points.pop_front();
                if (m_x_coord !== exp_pt.x)
                    report_mismatch($sformatf("index %0d: x got %0d want %0d",
                                              $signed(exp_pt.index), m_x_coord, exp_pt.x));
                if (m_y_coord !== exp_pt.y)
                    report_mismatch($sformatf("index %0d: y got %0d want %0d",
                                              $signed(exp_pt.index), m_y_coord, exp_pt.y));
            end
        end
    end

    // watchdog: cycles with no word moving on either channel
    always @(posedge aclk) begin
        if ((s_valid && s_ready) || (m_valid && m_ready))
            idle_cycles <= 0;
        else
            idle_cycles <= idle_cycles + 1;
        if (idle_cycles >= WDOG_LIMIT) begin
            $display("DONE: errors detected");
            $finish;
        end
    end

    initial begin
        repeat (7) @(posedge aclk);
        aresetn <= 1'b1;
        @(posedge aclk);

        test_extremes();
        test_first_rings();
        test_random_mix(1040);
        test_full_rate(250);
        test_random_mix(40);
        s_valid <= 1'b0;

        // drain, then let the pipe settle
        while (pending_points.size() != 0) @(posedge aclk);
        repeat (2 * LATENCY) @(posedge aclk);

        if (err_count == 0)
            $display("DONE: 0 errors");
        else
            $display("DONE: errors detected");
        $finish;
    end

endmodule
